[hdl/gpoe_pkg.sv]
// package for the grid pattern orbit enumerator
// holds grid geometry constants, command/status structs and colour tables
package gpoe_pkg;

  localparam int GRID_SIZE_DEF   = 4;
  localparam int COLOR_COUNT_DEF = 2;
  localparam int IDX_W           = 16;
  localparam int SIZE_W          = 9;
  localparam int MAP_DEPTH       = 65536;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BRICK  = 3'd0;
  localparam logic [2:0] REG_ROWSH  = 3'd1;
  localparam logic [2:0] REG_COLSH  = 3'd2;
  localparam logic [2:0] REG_ROT    = 3'd3;
  localparam logic [2:0] REG_TRANS  = 3'd4;
  localparam logic [2:0] REG_REFL   = 3'd5;
  localparam logic [2:0] REG_RECOL  = 3'd6;

  typedef struct packed {
    logic brick;
    logic row_shift;
    logic col_shift;
    logic rotation;
    logic transposition;
    logic reflection;
    logic recolor;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // decode new item into the working grid
    logic first;      // reset transform counters for a pass
    logic step;       // advance to next image
    logic rd;         // issue memory read for current image
    logic wr;         // read current image for marking, bit written next cycle
    logic clr;        // clear pass write
    logic clr_step;   // advance clear address
    logic out_load;   // capture result
  } cmd_t;

  // datapath status to controller
  typedef struct packed {
    logic last_image; // current image is the last of the orbit
    logic clr_done;   // clear address at top
    logic seen_bit;   // registered bitmap read data
    logic any_seen;   // some image of the orbit was already marked
  } sts_t;

  // colour permutation of three colours
  function automatic logic [1:0] recolor3(input logic [2:0] p, input logic [1:0] v);
    logic [1:0] r;
    r = v;
    unique case (p)
      3'd0: r = v;
      3'd1: r = (v == 2'd0) ? 2'd0 : (v == 2'd1) ? 2'd2 : 2'd1;
      3'd2: r = (v == 2'd0) ? 2'd1 : (v == 2'd1) ? 2'd0 : 2'd2;
      3'd3: r = (v == 2'd0) ? 2'd2 : (v == 2'd1) ? 2'd0 : 2'd1;
      3'd4: r = (v == 2'd0) ? 2'd1 : (v == 2'd1) ? 2'd2 : 2'd0;
      3'd5: r = (v == 2'd0) ? 2'd2 : (v == 2'd1) ? 2'd1 : 2'd0;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[hdl/grid_pattern_orbit_enumerator_core.sv]
// top level of the grid pattern orbit enumerator
// depends on gpoe_pkg, gpoe_ctrl, gpoe_datapath
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_pattern_index
// out      output     out_valid / out_stall  out_is_new, out_orbit_size, out_representative
// cfg      input      APB write/read         7 one-bit registers at 4*i
//
// after reset a clearing pass empties every address of the seen bitmap; no item is taken then
// an item runs a check pass with one bitmap read per enabled image, then, when no image of
// the orbit was already seen, a mark pass with one read per image; an orbit already seen skips
// the mark pass
// the result is held until out_stall is low; the next item waits until it is taken
module grid_pattern_orbit_enumerator_core
  import gpoe_pkg::*;
#(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int COLOR_COUNT = COLOR_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IDX_W-1:0]  in_pattern_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_new,
  output logic [SIZE_W-1:0] out_orbit_size,
  output logic [IDX_W-1:0]  out_representative,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{brick: 1'b0, row_shift: 1'b1, col_shift: 1'b1, rotation: 1'b1,
                 transposition: 1'b1, reflection: 1'b1, recolor: 1'b1};
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_BRICK: cfg_r.brick         <= cfg_pwdata[0];
        REG_ROWSH: cfg_r.row_shift     <= cfg_pwdata[0];
        REG_COLSH: cfg_r.col_shift     <= cfg_pwdata[0];
        REG_ROT:   cfg_r.rotation      <= cfg_pwdata[0];
        REG_TRANS: cfg_r.transposition <= cfg_pwdata[0];
        REG_REFL:  cfg_r.reflection    <= cfg_pwdata[0];
        REG_RECOL: cfg_r.recolor       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_BRICK: cfg_prdata[0] = cfg_r.brick;
      REG_ROWSH: cfg_prdata[0] = cfg_r.row_shift;
      REG_COLSH: cfg_prdata[0] = cfg_r.col_shift;
      REG_ROT:   cfg_prdata[0] = cfg_r.rotation;
      REG_TRANS: cfg_prdata[0] = cfg_r.transposition;
      REG_REFL:  cfg_prdata[0] = cfg_r.reflection;
      REG_RECOL: cfg_prdata[0] = cfg_r.recolor;
      default:   cfg_prdata = '0;
    endcase
  end

  gpoe_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd, .in_valid, .in_stall, .out_valid, .out_stall
  );

  gpoe_datapath #(.GRID_SIZE(GRID_SIZE), .COLOR_COUNT(COLOR_COUNT)) u_dp (
    .clk, .rst_n, .cfg(cfg_r), .cmd, .sts,
    .pattern_index(in_pattern_index),
    .is_new_o(out_is_new),
    .orbit_size_o(out_orbit_size),
    .representative_o(out_representative)
  );

endmodule

[hdl/gpoe_datapath.sv]
// datapath: grid transform counters, image number, seen bitmap memory
// depends on gpoe_pkg
module gpoe_datapath
  import gpoe_pkg::*;
#(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int COLOR_COUNT = COLOR_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IDX_W-1:0]  pattern_index,
  output logic              is_new_o,
  output logic [SIZE_W-1:0] orbit_size_o,
  output logic [IDX_W-1:0]  representative_o
);

  localparam int N      = GRID_SIZE;
  localparam int CW     = 2;
  localparam int SW     = $clog2(N);
  localparam int HALF   = N / 2;
  localparam bit BRICK_OK = (N % 2) == 0;

  typedef logic [CW-1:0] cell_t;

  // working grid for the item
  cell_t grid_r [N][N];
  cell_t grid_nxt [N][N];

  // transform counters
  logic [1:0]    rot_r;
  logic          tr_r, rf_r;
  logic [SW-1:0] row_r, col_r;
  logic [2:0]    perm_r;
  logic             any_seen_r;
  logic [SIZE_W-1:0] added_r;
  logic [IDX_W-1:0] rep_r_nxt;

  // memory
  logic              mem [MAP_DEPTH];
  logic              rd_data_r;
  logic [IDX_W-1:0]  clr_addr_r;
  logic [IDX_W-1:0]  img_num;
  logic [IDX_W-1:0]  wr_img_r;
  logic              wr_pend_r;
  logic              mark_pend_r;
  logic              fwd_r;

  // decode the index into the initial grid (digit per cell)
  always_comb begin
    logic [IDX_W-1:0] v;
    logic [IDX_W-1:0] q;
    cell_t d;
    v = pattern_index;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        grid_nxt[i][j] = '0;
    for (int i = N - 1; i >= 0; i--) begin
      for (int j = N - 1; j >= 0; j--) begin
        if (COLOR_COUNT == 2) begin
          d = cell_t'(v[0]);
          q = v >> 1;
        end else begin
          q = IDX_W'((32'(v) * 32'd43691) >> 17);
          d = CW'(v - IDX_W'(q * IDX_W'(3)));
        end
        if (cfg.brick && BRICK_OK) begin
          if (i < HALF) begin
            grid_nxt[i][j] = d;
            grid_nxt[HALF + i][(j + HALF) % N] = d;
            v = q;
          end
        end else begin
          grid_nxt[i][j] = d;
          v = q;
        end
      end
    end
  end

  // apply current transform combination and form the image number
  always_comb begin
    cell_t a [N][N];
    cell_t b [N][N];
    logic [IDX_W+1:0] num;
    logic [IDX_W+1:0] rep;
    cell_t c;
    int ri;
    int ci;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        a[i][j] = grid_r[i][j];
    // rotation: r times mirror(flip_diag)  a'[N-1-j][i] = a[i][j]
    for (int r = 0; r < 3; r++) begin
      if (r < int'(rot_r)) begin
        for (int i = 0; i < N; i++)
          for (int j = 0; j < N; j++)
            b[N-1-j][i] = a[i][j];
        a = b;
      end
    end
    if (tr_r) begin
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++)
          b[j][i] = a[i][j];
      a = b;
    end
    if (rf_r) begin
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++)
          b[N-1-i][j] = a[i][j];
      a = b;
    end
    // cyclic shifts: r.c[(i+m) mod N][(j+n) mod N] = c[i][j]
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        ri = i + int'(row_r);
        if (ri >= N) ri = ri - N;
        ci = j + int'(col_r);
        if (ci >= N) ci = ci - N;
        b[ri][ci] = a[i][j];
      end
    end
    num = '0;
    rep = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (COLOR_COUNT == 2) c = cell_t'(b[i][j][0] ^ perm_r[0]);
        else                  c = recolor3(perm_r, b[i][j]);
        num = (IDX_W+2)'(num * (IDX_W+2)'(COLOR_COUNT)) + (IDX_W+2)'(c);
        rep = (IDX_W+2)'(rep * (IDX_W+2)'(COLOR_COUNT)) + (IDX_W+2)'(grid_r[i][j]);
      end
    end
    img_num = num[IDX_W-1:0];
    rep_r_nxt = rep[IDX_W-1:0];
  end

  // limits of each counter
  logic [1:0]    rot_max;
  logic          tr_max, rf_max;
  logic [SW-1:0] row_max, col_max;
  logic [2:0]    perm_max;
  assign rot_max  = cfg.rotation ? 2'd3 : 2'd0;
  assign tr_max   = cfg.transposition;
  assign rf_max   = cfg.reflection;
  assign row_max  = cfg.row_shift ? SW'(N - 1) : '0;
  assign col_max  = cfg.col_shift ? SW'(N - 1) : '0;
  assign perm_max = cfg.recolor ? ((COLOR_COUNT == 2) ? 3'd1 : 3'd5) : 3'd0;

  assign sts.last_image = (rot_r == rot_max) && (tr_r == tr_max) && (rf_r == rf_max) &&
                          (row_r == row_max) && (col_r == col_max) && (perm_r == perm_max);
  assign sts.clr_done   = &clr_addr_r;
  assign sts.seen_bit   = rd_data_r;
  assign sts.any_seen   = any_seen_r;

  // grid and counters
  always_ff @(posedge clk) begin
    if (cmd.load) grid_r <= grid_nxt;
    if (cmd.first) begin
      rot_r <= '0; tr_r <= 1'b0; rf_r <= 1'b0;
      row_r <= '0; col_r <= '0; perm_r <= '0;
    end else if (cmd.step) begin
      // innermost counter is the colour permutation
      if (perm_r != perm_max) perm_r <= perm_r + 3'd1;
      else begin
        perm_r <= '0;
        if (col_r != col_max) col_r <= col_r + SW'(1);
        else begin
          col_r <= '0;
          if (row_r != row_max) row_r <= row_r + SW'(1);
          else begin
            row_r <= '0;
            if (rf_r != rf_max) rf_r <= 1'b1;
            else begin
              rf_r <= 1'b0;
              if (tr_r != tr_max) tr_r <= 1'b1;
              else begin
                tr_r <= 1'b0;
                rot_r <= rot_r + 2'd1;
              end
            end
          end
        end
      end
    end
  end

  // seen bitmap, registered read; in the mark pass the write trails its read through mark_pend_r
  always_ff @(posedge clk) begin
    if (cmd.clr) mem[clr_addr_r] <= 1'b0;
    else if (mark_pend_r) mem[wr_img_r] <= 1'b1;
    if (cmd.rd || cmd.wr) rd_data_r <= mem[img_num];
  end

  // clear address and orbit tallies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      any_seen_r  <= 1'b0;
      added_r     <= '0;
      wr_pend_r   <= 1'b0;
      mark_pend_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (cmd.load) begin
        any_seen_r <= 1'b0;
        added_r    <= '0;
      end
      // check pass: rd on image, data arrives next cycle
      wr_pend_r   <= cmd.rd;
      // mark pass: when the same image is read back to back, fwd_r keeps it from being counted twice
      mark_pend_r <= cmd.wr;
      wr_img_r    <= img_num;
      fwd_r       <= cmd.wr && mark_pend_r && (img_num == wr_img_r);
      if (wr_pend_r && rd_data_r) any_seen_r <= 1'b1;
      if (mark_pend_r && !rd_data_r && !fwd_r && added_r != '1)
        added_r <= added_r + SIZE_W'(1);
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_new_o         <= !any_seen_r;
      orbit_size_o     <= any_seen_r ? '0 : added_r;
      representative_o <= rep_r_nxt;
    end
  end

endmodule

[hdl/gpoe_ctrl.sv]
// controller: clearing pass, check pass, mark pass and result handshake
// depends on gpoe_pkg
module gpoe_ctrl
  import gpoe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          cmd.load = 1'b1;
          cmd.first = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.rd = 1'b1;
        cmd.step = !sts.last_image;
        if (sts.last_image) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last read data lands this cycle
        cmd.first = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        if (sts.any_seen) state_nxt = S_DONE;
        else begin
          cmd.wr = 1'b1;
          cmd.step = !sts.last_image;
          if (sts.last_image) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // write of the last image and its tally
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // no new item while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && out_valid_r) |-> in_stall) else $error("accept with result pending");
  // marking never happens during clearing
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.clr)) else $error("mark during clear");
  // result follows the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid_r) else $error("result lost");

endmodule

[verif/grid_pattern_orbit_enumerator_core_tb.sv]
// self-checking testbench for grid_pattern_orbit_enumerator_core
// depends on gpoe_pkg and the core rtl; holds an orbit predictor with its own seen bitmap
module grid_pattern_orbit_enumerator_core_tb;
  import gpoe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GS = 4;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic              is_new;
    logic [SIZE_W-1:0] orbit_size;
    logic [IDX_W-1:0]  representative;
  } orbit_res_t;

  typedef logic [GS-1:0][GS-1:0] grid_bits_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_pattern_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_new;
  logic [SIZE_W-1:0] out_orbit_size;
  logic [IDX_W-1:0] out_representative;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  grid_pattern_orbit_enumerator_core u_top (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit seen_bits [MAP_DEPTH];
  cfg_t sym_cfg;
  orbit_res_t pending_orbits [$];
  int mismatch_count = 0;
  int result_count = 0;
  int new_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [15:0] grid_to_number(grid_bits_t g);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < GS; i++)
      for (int j = 0; j < GS; j++)
        r = {r[14:0], g[i][j]};
    return r;
  endfunction

  function automatic grid_bits_t number_to_grid(logic [15:0] v, bit brick);
    grid_bits_t g;
    g = '0;
    for (int i = GS - 1; i >= 0; i--)
      for (int j = GS - 1; j >= 0; j--) begin
        if (brick && i >= GS / 2) continue;
        g[i][j] = v[0];
        if (brick) g[GS/2 + i][(j + GS/2) % GS] = v[0];
        v = v >> 1;
      end
    return g;
  endfunction

  function automatic grid_bits_t transpose_grid(grid_bits_t x);
    grid_bits_t r;
    for (int i = 0; i < GS; i++)
      for (int j = 0; j < GS; j++) r[j][i] = x[i][j];
    return r;
  endfunction

  function automatic grid_bits_t mirror_grid(grid_bits_t x);
    grid_bits_t r;
    for (int i = 0; i < GS; i++)
      for (int j = 0; j < GS; j++) r[GS-1-i][j] = x[i][j];
    return r;
  endfunction

  function automatic grid_bits_t roll_rows(grid_bits_t x);
    grid_bits_t r;
    for (int i = 0; i < GS; i++)
      for (int j = 0; j < GS; j++) r[(i+1)%GS][j] = x[i][j];
    return r;
  endfunction

  function automatic grid_bits_t roll_cols(grid_bits_t x);
    grid_bits_t r;
    for (int i = 0; i < GS; i++)
      for (int j = 0; j < GS; j++) r[i][(j+1)%GS] = x[i][j];
    return r;
  endfunction

  // orbit of one pattern, marks the bitmap when wholly unseen
  function automatic orbit_res_t enumerate_orbit(logic [15:0] idx);
    orbit_res_t res;
    grid_bits_t a, b, c, d, e, init;
    logic [15:0] imgs [$];
    bit any_seen;
    int added;
    init = number_to_grid(idx, sym_cfg.brick);
    a = init;
    for (int r = 0; r < (sym_cfg.rotation ? 4 : 1); r++) begin
      b = a;
      for (int t = 0; t < (sym_cfg.transposition ? 2 : 1); t++) begin
        c = b;
        for (int f = 0; f < (sym_cfg.reflection ? 2 : 1); f++) begin
          d = c;
          for (int m = 0; m < (sym_cfg.row_shift ? GS : 1); m++) begin
            e = d;
            for (int n = 0; n < (sym_cfg.col_shift ? GS : 1); n++) begin
              for (int p = 0; p < (sym_cfg.recolor ? 2 : 1); p++)
                imgs.push_back(p ? ~grid_to_number(e) : grid_to_number(e));
              e = roll_cols(e);
            end
            d = roll_rows(d);
          end
          c = mirror_grid(c);
        end
        b = transpose_grid(b);
      end
      a = mirror_grid(transpose_grid(a));
    end
    any_seen = 1'b0;
    foreach (imgs[k]) if (seen_bits[imgs[k]]) any_seen = 1'b1;
    added = 0;
    if (!any_seen)
      foreach (imgs[k])
        if (!seen_bits[imgs[k]]) begin
          seen_bits[imgs[k]] = 1'b1;
          added++;
        end
    if (added > 511) added = 511;
    res.is_new = !any_seen;
    res.orbit_size = added[SIZE_W-1:0];
    res.representative = grid_to_number(init);
    return res;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_pattern_orbit_enumerator_core regression: fail");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // result checker
  always @(posedge clk) begin
    orbit_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_orbits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: %0d %0d %h", out_is_new, out_orbit_size,
                   out_representative);
      end else begin
        want = pending_orbits.pop_front();
        if (want.is_new) new_count++;
        if (want.is_new !== out_is_new || want.orbit_size !== out_orbit_size ||
            want.representative !== out_representative) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: want %0d %0d %h got %0d %0d %h", want.is_new,
                     want.orbit_size, want.representative, out_is_new, out_orbit_size,
                     out_representative);
        end
      end
    end
  end

  // one input transaction
  task automatic send_pattern(logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_pattern_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_orbits.push_back(enumerate_orbit(idx));
    sent_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_orbits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // register write over the configuration port
  task automatic write_reg(logic [2:0] idx, bit val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {31'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic apply_cfg(cfg_t c);
    wait_drained();
    write_reg(REG_BRICK, c.brick);
    write_reg(REG_ROWSH, c.row_shift);
    write_reg(REG_COLSH, c.col_shift);
    write_reg(REG_ROT, c.rotation);
    write_reg(REG_TRANS, c.transposition);
    write_reg(REG_REFL, c.reflection);
    write_reg(REG_RECOL, c.recolor);
    sym_cfg = c;
  endtask

  // directed: field extremes, repeats, every transform alone, brick mode
  task automatic test_directed();
    send_pattern(16'h0000);
    send_pattern(16'hFFFF);
    send_pattern(16'h0000);
    send_pattern(16'h8001);
    send_pattern(16'h1234);
    send_pattern(16'h5555);
    for (int k = 0; k < 6; k++) begin
      apply_cfg(cfg_t'(7'b0000000 | (7'b1 << k)));
      send_pattern(16'h0001 << k);
      send_pattern(16'hA5C3);
    end
    // partly seen orbit after a register change
    apply_cfg(7'b0111111);
    send_pattern(16'h0007);
    apply_cfg(7'b1111111);
    send_pattern(16'h00FF);
    send_pattern(16'hFF00);
    send_pattern(16'h0E17);
  endtask

  // random items across random settings
  task automatic test_random(int count);
    cfg_t c;
    for (int i = 0; i < count; i++) begin
      if (i % 130 == 0) begin
        c = cfg_t'(7'($urandom_range(127)));
        if (i % 390 == 0) c = '1;
        apply_cfg(c);
      end
      if (i == count / 2) wait_drained();
      send_pattern(16'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    sym_cfg = 7'b0111111;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 63;
    test_directed();
    test_random(380);
    send_idle_pct = 63;
    recv_idle_pct = 37;
    test_random(380);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(380);
    apply_cfg('0);
    wait_drained();
    $display("%0d patterns sent, %0d results, %0d new orbits, over random symmetry settings",
             sent_count, result_count, new_count);
    if (mismatch_count == 0 && pending_orbits.size() == 0)
      $display("grid_pattern_orbit_enumerator_core regression: pass");
    else
      $display("grid_pattern_orbit_enumerator_core regression: fail");
    $finish;
  end
endmodule
